// ===== hw/rtl/pending_request_aging_table_assert.svh =====
// Assertion macros, clocked on clk and disabled while arst_n is low.
`ifndef PENDING_REQUEST_AGING_TABLE_ASSERT_SVH
`define PENDING_REQUEST_AGING_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRAT_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define PRAT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define PRAT_ASSERT_NOW(lbl, pre, post, msg)
`define PRAT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/prat_pkg.sv =====
package prat_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [7:0] LIFETIME_RESET = 8'd30;
	localparam logic [4:0] COUNT_MAX = 5'd31;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_POP    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_INS  = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] addr;
		logic [15:0] port;
		logic [7:0]  life;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        take;
		logic [31:0] age;
		logic [7:0]  life_next;
		logic        expire;
	} scan_res_t;
endpackage

// ===== hw/rtl/prat_if.sv =====
interface prat_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] request_key;
	logic [31:0] peer_addr;
	logic [15:0] peer_port;

	modport source(output valid, cmd, request_key, peer_addr, peer_port, input ready);
	modport sink(input valid, cmd, request_key, peer_addr, peer_port, output ready);
endinterface

interface prat_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] found_addr;
	logic [15:0] found_port;
	logic [4:0]  expired_count;

	modport source(output valid, status, found_addr, found_port, expired_count, input ready);
	modport sink(input valid, status, found_addr, found_port, expired_count, output ready);
endinterface

// ===== hw/rtl/prat_ram.sv =====
module prat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/prat_scan_unit.sv =====
module prat_scan_unit (
	input  prat_pkg::entry_t    ent,
	input  logic                vld,
	input  logic [31:0]         key,
	input  logic [31:0]         counter,
	input  logic                found,
	input  logic [31:0]         best_age,
	output prat_pkg::scan_res_t res
);
	always_comb begin
		res.age       = counter - ent.stamp;
		res.take      = vld && (ent.key == key) && (!found || (res.age > best_age));
		res.life_next = ent.life - 8'd1;
		res.expire    = vld && (res.life_next == 8'd0);
	end
endmodule

// ===== hw/rtl/pending_request_aging_table.sv =====
// channel  | dir | handshake     | word
// in_ch    | in  | valid/ready   | cmd, request_key, peer_addr, peer_port
// out_ch   | out | valid/ready   | status, found_addr, found_port, expired_count
// cfg      | in  | cfg_we        | cfg_wdata = entry_lifetime
// Insert: probes slots upward from slot 0 and fills the lowest free one (status full if none), then emits.
// Tick and pop: walk all TABLE_DEPTH slots, one slot per cycle through the entry RAM
// read port, then emit.
// Reset clears the slot valid flops at once; no clearing pass.
// Results sit in an output register; the next word is taken while it waits.
module pending_request_aging_table (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	prat_in_if.sink    in_ch,
	prat_out_if.source out_ch
);
	prat_pkg::state_t              state_q;
	prat_pkg::cmd_t                cmd_q;
	logic [31:0]                   key_q;
	logic [31:0]                   addr_q;
	logic [15:0]                   port_q;
	logic [prat_pkg::IDX_W-1:0]    idx_q;
	logic                          issue_q;
	logic                          rdv_q;
	logic [prat_pkg::IDX_W-1:0]    rdidx_q;
	logic [prat_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [31:0]                   counter_q;
	logic [7:0]                    life_cfg_q;
	logic                          found_q;
	logic [prat_pkg::IDX_W-1:0]    best_idx_q;
	logic [31:0]                   best_age_q;
	logic [31:0]                   best_addr_q;
	logic [15:0]                   best_port_q;
	logic [4:0]                    exp_q;
	logic                          full_q;
	logic                          out_valid_q;
	logic [1:0]                    out_status_q;
	logic [31:0]                   out_addr_q;
	logic [15:0]                   out_port_q;
	logic [4:0]                    out_exp_q;

	logic                          accept;
	logic                          emit;
	logic                          ram_we;
	logic [prat_pkg::IDX_W-1:0]    ram_waddr;
	prat_pkg::entry_t              ram_wdata;
	prat_pkg::entry_t              ram_rdata;
	prat_pkg::scan_res_t           sres;
	logic                          slot_free;
	logic [1:0]                    done_status;

	assign accept    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == prat_pkg::S_IDLE);
	assign emit      = (state_q == prat_pkg::S_DONE) && (!out_valid_q || out_ch.ready);
	assign slot_free = !valid_q[idx_q];

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.found_addr    = out_addr_q;
	assign out_ch.found_port    = out_port_q;
	assign out_ch.expired_count = out_exp_q;

	prat_ram #(
		.WIDTH(prat_pkg::ENTRY_W),
		.DEPTH(prat_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   ((state_q == prat_pkg::S_SCAN) && issue_q),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	prat_scan_unit u_scan (
		.ent     (ram_rdata),
		.vld     (valid_q[rdidx_q]),
		.key     (key_q),
		.counter (counter_q),
		.found   (found_q),
		.best_age(best_age_q),
		.res     (sres)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		if (state_q == prat_pkg::S_INS) begin
			ram_we          = slot_free;
			ram_waddr       = idx_q;
			ram_wdata.key   = key_q;
			ram_wdata.addr  = addr_q;
			ram_wdata.port  = port_q;
			ram_wdata.life  = life_cfg_q;
			ram_wdata.stamp = counter_q;
		end else if (state_q == prat_pkg::S_SCAN && cmd_q == prat_pkg::CMD_TICK) begin
			ram_we         = rdv_q && valid_q[rdidx_q];
			ram_waddr      = rdidx_q;
			ram_wdata.life = sres.life_next;
		end
	end

	always_comb begin
		case (cmd_q)
			prat_pkg::CMD_INSERT: done_status = full_q ? prat_pkg::ST_FULL : prat_pkg::ST_OK;
			prat_pkg::CMD_POP:    done_status = found_q ? prat_pkg::ST_OK
			                                            : prat_pkg::ST_NOT_FOUND;
			default:              done_status = prat_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prat_pkg::S_IDLE;
			cmd_q       <= prat_pkg::CMD_NONE;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			rdv_q       <= 1'b0;
			rdidx_q     <= '0;
			valid_q     <= '0;
			counter_q   <= '0;
			life_cfg_q  <= prat_pkg::LIFETIME_RESET;
			found_q     <= 1'b0;
			exp_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				life_cfg_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				prat_pkg::S_IDLE: begin
					if (accept) begin
						cmd_q   <= prat_pkg::cmd_t'(in_ch.cmd);
						idx_q   <= '0;
						issue_q <= 1'b1;
						rdv_q   <= 1'b0;
						found_q <= 1'b0;
						exp_q   <= '0;
						full_q  <= 1'b0;
						case (prat_pkg::cmd_t'(in_ch.cmd))
							prat_pkg::CMD_INSERT: state_q <= prat_pkg::S_INS;
							prat_pkg::CMD_TICK,
							prat_pkg::CMD_POP:    state_q <= prat_pkg::S_SCAN;
							default:              state_q <= prat_pkg::S_DONE;
						endcase
					end
				end
				prat_pkg::S_INS: begin
					if (slot_free) begin
						valid_q[idx_q] <= 1'b1;
						counter_q      <= counter_q + 32'd1;
						state_q        <= prat_pkg::S_DONE;
					end else if (idx_q == prat_pkg::IDX_LAST) begin
						full_q  <= 1'b1;
						state_q <= prat_pkg::S_DONE;
					end else begin
						idx_q <= idx_q + prat_pkg::IDX_W'(1);
					end
				end
				prat_pkg::S_SCAN: begin
					rdv_q   <= issue_q;
					rdidx_q <= idx_q;
					if (issue_q) begin
						if (idx_q == prat_pkg::IDX_LAST) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + prat_pkg::IDX_W'(1);
						end
					end
					if (rdv_q) begin
						if (cmd_q == prat_pkg::CMD_TICK) begin
							if (sres.expire) begin
								valid_q[rdidx_q] <= 1'b0;
								if (exp_q != prat_pkg::COUNT_MAX) begin
									exp_q <= exp_q + 5'd1;
								end
							end
						end else if (sres.take) begin
							found_q <= 1'b1;
						end
						if (rdidx_q == prat_pkg::IDX_LAST) begin
							state_q <= prat_pkg::S_DONE;
						end
					end
				end
				prat_pkg::S_DONE: begin
					if (emit) begin
						if (cmd_q == prat_pkg::CMD_POP && found_q) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						state_q <= prat_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= prat_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= in_ch.request_key;
			addr_q <= in_ch.peer_addr;
			port_q <= in_ch.peer_port;
		end
		if (state_q == prat_pkg::S_SCAN && rdv_q && cmd_q == prat_pkg::CMD_POP && sres.take) begin
			best_idx_q  <= rdidx_q;
			best_age_q  <= sres.age;
			best_addr_q <= ram_rdata.addr;
			best_port_q <= ram_rdata.port;
		end
		if (emit) begin
			out_status_q <= done_status;
			out_addr_q   <= (cmd_q == prat_pkg::CMD_POP && found_q) ? best_addr_q : 32'd0;
			out_port_q   <= (cmd_q == prat_pkg::CMD_POP && found_q) ? best_port_q : 16'd0;
			out_exp_q    <= (cmd_q == prat_pkg::CMD_TICK) ? exp_q : 5'd0;
		end
	end

`include "pending_request_aging_table_assert.svh"

	`PRAT_ASSERT_NEXT(a_insert_adds_one, state_q == prat_pkg::S_INS && slot_free, $countones(valid_q) == $past($countones(valid_q)) + 1, "insert did not add exactly one slot")
	`PRAT_ASSERT_NEXT(a_tick_no_growth, state_q == prat_pkg::S_SCAN && cmd_q == prat_pkg::CMD_TICK, $countones(valid_q) <= $past($countones(valid_q)), "tick added a slot")
	`PRAT_ASSERT_NOW(a_miss_zero, out_valid_q && out_status_q != prat_pkg::ST_OK, out_addr_q == 32'd0 && out_port_q == 16'd0 && out_exp_q == 5'd0, "failed result carries data")
	`PRAT_ASSERT_NOW(a_scan_stop, state_q == prat_pkg::S_SCAN && !issue_q, rdv_q || state_q != prat_pkg::S_SCAN, "scan stalled with nothing in flight")
endmodule
